### rtl/exif_orientation_sniffer_defines.svh
// Assertion macros for the Exif orientation sniffer.
`ifndef EXIF_ORIENTATION_SNIFFER_DEFINES_SVH
`define EXIF_ORIENTATION_SNIFFER_DEFINES_SVH
`ifndef SYNTHESIS
// Checks prop on every clock edge outside reset.
`define EOS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("exif orientation sniffer check failed");
// Checks that cons holds in the cycle after ante.
`define EOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("exif orientation sniffer sequence check failed");
`else
`define EOS_ASSERT(lbl, clk, rst_n, prop)
`define EOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/eos_pkg.sv
// Shared types and constants of the Exif orientation sniffer.
package eos_pkg;

	// One input beat: a file byte and its end-of-file mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	// One result beat
	typedef struct packed {
		logic [3:0] orientation;
		logic       swaps_axes;
	} out_beat_t;

	// Byte handed from the input register to the parser
	typedef struct packed {
		logic     go;
		in_beat_t beat;
	} step_t;

	// Parse phases
	localparam logic [3:0] PH_START    = 4'd0;
	localparam logic [3:0] PH_JSOI     = 4'd1;
	localparam logic [3:0] PH_JFF      = 4'd2;
	localparam logic [3:0] PH_JMARK    = 4'd3;
	localparam logic [3:0] PH_JLEN     = 4'd4;
	localparam logic [3:0] PH_JEXIF    = 4'd5;
	localparam logic [3:0] PH_JSKIP    = 4'd6;
	localparam logic [3:0] PH_PSIG     = 4'd7;
	localparam logic [3:0] PH_PHDR     = 4'd8;
	localparam logic [3:0] PH_PSKIP    = 4'd9;
	localparam logic [3:0] PH_THDR     = 4'd10;
	localparam logic [3:0] PH_TSKIP    = 4'd11;
	localparam logic [3:0] PH_TCNT     = 4'd12;
	localparam logic [3:0] PH_TENT     = 4'd13;
	localparam logic [3:0] PH_TENTSKIP = 4'd14;
	localparam logic [3:0] PH_DONE     = 4'd15;

	// Container and TIFF constants
	localparam logic [7:0]  JPEG_FILL   = 8'hFF;
	localparam logic [7:0]  JPEG_SOI    = 8'hD8;
	localparam logic [7:0]  JPEG_TEM    = 8'h01;
	localparam logic [7:0]  JPEG_SOS    = 8'hDA;
	localparam logic [7:0]  JPEG_EOI    = 8'hD9;
	localparam logic [7:0]  JPEG_RST0   = 8'hD0;
	localparam logic [7:0]  JPEG_RST7   = 8'hD7;
	localparam logic [7:0]  JPEG_APP1   = 8'hE1;
	localparam logic [7:0]  PNG_LEAD    = 8'h89;
	localparam logic [7:0]  TIFF_LE     = 8'h49;
	localparam logic [7:0]  TIFF_BE     = 8'h4D;
	localparam logic [31:0] TIFF_MAGIC  = 32'd42;
	localparam logic [15:0] TAG_ORIENT  = 16'h0112;
	localparam logic [15:0] TYPE_SHORT  = 16'd3;
	localparam logic [15:0] TYPE_LONG   = 16'd4;
	localparam logic [3:0]  CODE_NONE   = 4'd1;
	localparam logic [3:0]  CODE_MAX    = 4'd8;
	localparam logic [3:0]  CODE_SWAP   = 4'd5;

endpackage

### rtl/eos_in_stage.sv
// Input register: holds one byte beat until the parser takes it.
module eos_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  eos_pkg::in_beat_t  byte_data,
	input  logic               take,
	output logic               valid_s1,
	output eos_pkg::in_beat_t  beat_s1
);

	// Full and not drained this cycle
	assign byte_stall = valid_s1 && !take;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			beat_s1 <= byte_data;
		end
	end

endmodule

### rtl/eos_parser.sv
// Byte-wise container and IFD0 walker that finds the orientation tag.
module eos_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  eos_pkg::step_t      step,
	output eos_pkg::out_beat_t  res
);

	logic [3:0]  ph_q, ph_n;
	logic [3:0]  idx_q, idx_n;
	logic [31:0] skip_q, skip_n;
	logic        big_q, big_n;
	logic [31:0] fs_q, fs_n;
	logic [15:0] ent_q, ent_n;
	logic        short_q, short_n;
	logic [7:0]  mark_q, mark_n;
	logic [3:0]  code_q, code_n;

	// Add byte b at position pos of a multi-byte field
	function automatic logic [31:0] gather(input logic [31:0] fs, input logic [1:0] pos,
			input logic [7:0] b, input logic big);
		logic [31:0] base;
		base = (pos == 2'd0) ? 32'd0 : fs;
		if (big) begin
			gather = {base[23:0], b};
		end else begin
			gather = base | ({24'd0, b} << {pos, 3'b000});
		end
	endfunction

	function automatic logic [7:0] exif_magic(input logic [2:0] i);
		unique case (i)
			3'd0:    exif_magic = 8'h45;
			3'd1:    exif_magic = 8'h78;
			3'd2:    exif_magic = 8'h69;
			3'd3:    exif_magic = 8'h66;
			default: exif_magic = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] png_magic(input logic [2:0] i);
		unique case (i)
			3'd0:    png_magic = 8'h89;
			3'd1:    png_magic = 8'h50;
			3'd2:    png_magic = 8'h4E;
			3'd3:    png_magic = 8'h47;
			3'd4:    png_magic = 8'h0D;
			3'd5:    png_magic = 8'h0A;
			3'd6:    png_magic = 8'h1A;
			default: png_magic = 8'h0A;
		endcase
	endfunction

	// "eXIf" chunk type
	function automatic logic [7:0] exif_tag(input logic [1:0] i);
		unique case (i)
			2'd0:    exif_tag = 8'h65;
			2'd1:    exif_tag = 8'h58;
			2'd2:    exif_tag = 8'h49;
			default: exif_tag = 8'h66;
		endcase
	endfunction

	// "IDAT" chunk type
	function automatic logic [7:0] idat_tag(input logic [1:0] i);
		unique case (i)
			2'd0:    idat_tag = 8'h49;
			2'd1:    idat_tag = 8'h44;
			2'd2:    idat_tag = 8'h41;
			default: idat_tag = 8'h54;
		endcase
	endfunction

	// Next state for one byte
	always_comb begin
		logic [7:0]  b;
		logic [3:0]  k;
		logic [31:0] g;
		logic [31:0] v;
		logic [31:0] kw;
		logic [7:0]  m;
		logic [15:0] e;
		b = step.beat.data_byte;
		k = idx_q;
		kw = {28'd0, idx_q};
		g = '0;
		v = '0;
		m = mark_q;
		e = ent_q;
		ph_n = ph_q;
		idx_n = idx_q;
		skip_n = skip_q;
		big_n = big_q;
		fs_n = fs_q;
		ent_n = ent_q;
		short_n = short_q;
		mark_n = mark_q;
		code_n = code_q;
		if (step.go) begin
			unique case (ph_q)
				eos_pkg::PH_START: begin
					if (b == eos_pkg::JPEG_FILL) begin
						ph_n = eos_pkg::PH_JSOI;
					end else if (b == eos_pkg::PNG_LEAD) begin
						ph_n = eos_pkg::PH_PSIG;
						idx_n = 4'd1;
					end else if (b == eos_pkg::TIFF_LE || b == eos_pkg::TIFF_BE) begin
						mark_n = b;
						big_n = (b == eos_pkg::TIFF_BE);
						ph_n = eos_pkg::PH_THDR;
						idx_n = 4'd1;
					end else begin
						ph_n = eos_pkg::PH_DONE;
						code_n = eos_pkg::CODE_NONE;
					end
				end
				eos_pkg::PH_JSOI: begin
					if (b != eos_pkg::JPEG_SOI) begin
						ph_n = eos_pkg::PH_DONE;
						code_n = eos_pkg::CODE_NONE;
					end else begin
						ph_n = eos_pkg::PH_JFF;
					end
				end
				eos_pkg::PH_JFF: begin
					if (b != eos_pkg::JPEG_FILL) begin
						ph_n = eos_pkg::PH_DONE;
						code_n = eos_pkg::CODE_NONE;
					end else begin
						ph_n = eos_pkg::PH_JMARK;
					end
				end
				eos_pkg::PH_JMARK: begin
					// fill bytes stay here; standalone markers carry no length
					if (b == eos_pkg::JPEG_FILL) begin
						ph_n = eos_pkg::PH_JMARK;
					end else if (b == eos_pkg::JPEG_SOI || b == eos_pkg::JPEG_TEM ||
							(b >= eos_pkg::JPEG_RST0 && b <= eos_pkg::JPEG_RST7)) begin
						ph_n = eos_pkg::PH_JFF;
					end else if (b == eos_pkg::JPEG_SOS || b == eos_pkg::JPEG_EOI) begin
						ph_n = eos_pkg::PH_DONE;
						code_n = eos_pkg::CODE_NONE;
					end else begin
						mark_n = b;
						ph_n = eos_pkg::PH_JLEN;
						idx_n = 4'd0;
					end
				end
				eos_pkg::PH_JLEN: begin
					g = gather(fs_q, k[1:0], b, 1'b1);
					fs_n = g;
					if (k == 4'd0) begin
						idx_n = 4'd1;
					end else if (g < 32'd2) begin
						ph_n = eos_pkg::PH_DONE;
						code_n = eos_pkg::CODE_NONE;
					end else begin
						skip_n = g - 32'd2;
						idx_n = 4'd0;
						if (mark_q == eos_pkg::JPEG_APP1) begin
							ph_n = eos_pkg::PH_JEXIF;
						end else if (g == 32'd2) begin
							ph_n = eos_pkg::PH_JFF;
						end else begin
							ph_n = eos_pkg::PH_JSKIP;
						end
					end
				end
				eos_pkg::PH_JEXIF: begin
					// on a mismatch, resume at the segment's stated end
					if (k < 4'd6 && b == exif_magic(k[2:0])) begin
						if (k == 4'd5) begin
							ph_n = eos_pkg::PH_THDR;
							idx_n = 4'd0;
						end else begin
							idx_n = k + 4'd1;
						end
					end else if (skip_q < kw) begin
						ph_n = eos_pkg::PH_DONE;
						code_n = eos_pkg::CODE_NONE;
					end else if (skip_q == kw) begin
						if (b != eos_pkg::JPEG_FILL) begin
							ph_n = eos_pkg::PH_DONE;
							code_n = eos_pkg::CODE_NONE;
						end else begin
							ph_n = eos_pkg::PH_JMARK;
						end
					end else begin
						skip_n = skip_q - kw - 32'd1;
						ph_n = (skip_q == kw + 32'd1) ? eos_pkg::PH_JFF : eos_pkg::PH_JSKIP;
					end
				end
				eos_pkg::PH_JSKIP: begin
					skip_n = skip_q - 32'd1;
					if (skip_q == 32'd1) begin
						ph_n = eos_pkg::PH_JFF;
					end
				end
				eos_pkg::PH_PSIG: begin
					if (k > 4'd7 || b != png_magic(k[2:0])) begin
						ph_n = eos_pkg::PH_DONE;
						code_n = eos_pkg::CODE_NONE;
					end else if (k == 4'd7) begin
						ph_n = eos_pkg::PH_PHDR;
						idx_n = 4'd0;
					end else begin
						idx_n = k + 4'd1;
					end
				end
				eos_pkg::PH_PHDR: begin
					// chunk length, then type matched against eXIf and IDAT
					if (k < 4'd4) begin
						fs_n = gather(fs_q, k[1:0], b, 1'b1);
						if (k == 4'd0) begin
							mark_n = 8'd3;
						end
						idx_n = k + 4'd1;
					end else if (k > 4'd7) begin
						ph_n = eos_pkg::PH_DONE;
						code_n = eos_pkg::CODE_NONE;
					end else begin
						if (b != exif_tag(k[1:0])) begin
							m[0] = 1'b0;
						end
						if (b != idat_tag(k[1:0])) begin
							m[1] = 1'b0;
						end
						mark_n = m;
						if (k < 4'd7) begin
							idx_n = k + 4'd1;
						end else if (m[0]) begin
							ph_n = eos_pkg::PH_THDR;
							idx_n = 4'd0;
						end else if (m[1] || fs_q[31]) begin
							ph_n = eos_pkg::PH_DONE;
							code_n = eos_pkg::CODE_NONE;
						end else begin
							skip_n = fs_q + 32'd4;
							ph_n = eos_pkg::PH_PSKIP;
						end
					end
				end
				eos_pkg::PH_PSKIP: begin
					skip_n = skip_q - 32'd1;
					if (skip_q == 32'd1) begin
						ph_n = eos_pkg::PH_PHDR;
						idx_n = 4'd0;
					end
				end
				eos_pkg::PH_THDR: begin
					// byte-order mark, 42, IFD0 offset
					if (k == 4'd0) begin
						if (b != eos_pkg::TIFF_LE && b != eos_pkg::TIFF_BE) begin
							ph_n = eos_pkg::PH_DONE;
							code_n = eos_pkg::CODE_NONE;
						end else begin
							mark_n = b;
							big_n = (b == eos_pkg::TIFF_BE);
							idx_n = 4'd1;
						end
					end else if (k == 4'd1) begin
						if (b != mark_q) begin
							ph_n = eos_pkg::PH_DONE;
							code_n = eos_pkg::CODE_NONE;
						end else begin
							idx_n = 4'd2;
						end
					end else if (k <= 4'd3) begin
						g = gather(fs_q, {1'b0, k[0]}, b, big_q);
						fs_n = g;
						if (k == 4'd3 && g != eos_pkg::TIFF_MAGIC) begin
							ph_n = eos_pkg::PH_DONE;
							code_n = eos_pkg::CODE_NONE;
						end else begin
							idx_n = k + 4'd1;
						end
					end else begin
						g = gather(fs_q, k[1:0], b, big_q);
						fs_n = g;
						if (k >= 4'd7) begin
							if (g < 32'd8) begin
								ph_n = eos_pkg::PH_DONE;
								code_n = eos_pkg::CODE_NONE;
							end else begin
								skip_n = g - 32'd8;
								idx_n = 4'd0;
								ph_n = (g == 32'd8) ? eos_pkg::PH_TCNT : eos_pkg::PH_TSKIP;
							end
						end else begin
							idx_n = k + 4'd1;
						end
					end
				end
				eos_pkg::PH_TSKIP: begin
					skip_n = skip_q - 32'd1;
					if (skip_q == 32'd1) begin
						ph_n = eos_pkg::PH_TCNT;
						idx_n = 4'd0;
					end
				end
				eos_pkg::PH_TCNT: begin
					g = gather(fs_q, {1'b0, k[0]}, b, big_q);
					fs_n = g;
					if (k == 4'd0) begin
						idx_n = 4'd1;
					end else begin
						ent_n = g[15:0];
						if (g[15:0] == 16'd0) begin
							ph_n = eos_pkg::PH_DONE;
							code_n = eos_pkg::CODE_NONE;
						end else begin
							ph_n = eos_pkg::PH_TENT;
							idx_n = 4'd0;
						end
					end
				end
				eos_pkg::PH_TENT: begin
					// tag, type, count, value of one 12-byte entry
					g = gather(fs_q, k[1:0], b, big_q);
					fs_n = g;
					if (k == 4'd1) begin
						if (g[15:0] != eos_pkg::TAG_ORIENT) begin
							skip_n = 32'd10;
							ph_n = eos_pkg::PH_TENTSKIP;
						end else begin
							idx_n = 4'd2;
						end
					end else if (k == 4'd3) begin
						short_n = (g[15:0] == eos_pkg::TYPE_SHORT);
						if (g[15:0] != eos_pkg::TYPE_SHORT && g[15:0] != eos_pkg::TYPE_LONG) begin
							ph_n = eos_pkg::PH_DONE;
							code_n = eos_pkg::CODE_NONE;
						end else begin
							idx_n = 4'd4;
						end
					end else if (k == 4'd7) begin
						if (g != 32'd1) begin
							ph_n = eos_pkg::PH_DONE;
							code_n = eos_pkg::CODE_NONE;
						end else begin
							idx_n = 4'd8;
						end
					end else if (k == 4'd11) begin
						if (short_q) begin
							v = big_q ? {16'd0, g[31:16]} : {16'd0, g[15:0]};
						end else begin
							v = g;
						end
						ph_n = eos_pkg::PH_DONE;
						if (v >= 32'd1 && v <= {28'd0, eos_pkg::CODE_MAX}) begin
							code_n = v[3:0];
						end else begin
							code_n = eos_pkg::CODE_NONE;
						end
					end else begin
						idx_n = k + 4'd1;
					end
				end
				eos_pkg::PH_TENTSKIP: begin
					skip_n = skip_q - 32'd1;
					if (skip_q == 32'd1) begin
						e = ent_q - 16'd1;
						ent_n = e;
						if (e == 16'd0) begin
							ph_n = eos_pkg::PH_DONE;
							code_n = eos_pkg::CODE_NONE;
						end else begin
							ph_n = eos_pkg::PH_TENT;
							idx_n = 4'd0;
						end
					end
				end
				eos_pkg::PH_DONE: begin
					// decided: ignore bytes until the end of the file
					ph_n = ph_q;
				end
			endcase
		end
	end

	// Result as seen after this byte
	assign res.orientation = code_n;
	assign res.swaps_axes  = (code_n >= eos_pkg::CODE_SWAP);

	// State update; the last byte returns everything to start of file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= eos_pkg::PH_START;
			idx_q   <= '0;
			skip_q  <= '0;
			big_q   <= 1'b0;
			fs_q    <= '0;
			ent_q   <= '0;
			short_q <= 1'b0;
			mark_q  <= '0;
			code_q  <= eos_pkg::CODE_NONE;
		end else if (step.go) begin
			if (step.beat.last_byte) begin
				ph_q    <= eos_pkg::PH_START;
				idx_q   <= '0;
				skip_q  <= '0;
				big_q   <= 1'b0;
				fs_q    <= '0;
				ent_q   <= '0;
				short_q <= 1'b0;
				mark_q  <= '0;
				code_q  <= eos_pkg::CODE_NONE;
			end else begin
				ph_q    <= ph_n;
				idx_q   <= idx_n;
				skip_q  <= skip_n;
				big_q   <= big_n;
				fs_q    <= fs_n;
				ent_q   <= ent_n;
				short_q <= short_n;
				mark_q  <= mark_n;
				code_q  <= code_n;
			end
		end
	end

endmodule

### rtl/exif_orientation_sniffer.sv
// Exif orientation sniffer: top level with input register, parser and result register.
// Takes one file byte per clock (unless the byte channel stalls) and, on the byte flagged
// last_byte, gives one result beat with the Exif orientation (1 to 8, 1 when absent or
// invalid) and the axis-swap flag. JPEG, PNG and bare TIFF inputs are recognized from the
// first byte. A byte is parsed during the cycle it sits in the input register, so the
// result is valid in the cycle after the last byte is taken. The byte channel stalls
// only while a last byte waits behind an earlier result that is itself still stalled.
`include "exif_orientation_sniffer_defines.svh"

module exif_orientation_sniffer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  eos_pkg::in_beat_t   byte_data,
	output logic                result_valid,
	input  logic                result_stall,
	output eos_pkg::out_beat_t  result_data
);

	logic                valid_s1;
	eos_pkg::in_beat_t   beat_s1;
	logic                take;
	eos_pkg::step_t      step;
	eos_pkg::out_beat_t  res;
	logic                result_valid_q;
	eos_pkg::out_beat_t  result_data_q;
	logic                last_take;
	logic                code_ok;
	logic                swap_ok;

	// A non-last byte always moves; a last byte needs room in the result register
	assign take = valid_s1 &&
		(!beat_s1.last_byte || !result_valid_q || !result_stall);
	assign step.go   = take;
	assign step.beat = beat_s1;

	eos_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.take       (take),
		.valid_s1   (valid_s1),
		.beat_s1    (beat_s1)
	);

	eos_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take && beat_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && beat_s1.last_byte) begin
			result_data_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_data_q;

	// Check terms
	assign last_take = take && beat_s1.last_byte;
	assign code_ok   = (result_data.orientation >= eos_pkg::CODE_NONE) &&
		(result_data.orientation <= eos_pkg::CODE_MAX);
	assign swap_ok   = (result_data.swaps_axes == (result_data.orientation >= eos_pkg::CODE_SWAP));

	// Checks
	`EOS_ASSERT(a_code_range, clk, arst_n, result_valid |-> code_ok)
	`EOS_ASSERT(a_swap_match, clk, arst_n, result_valid |-> swap_ok)
	`EOS_ASSERT_NEXT(a_last_loads, clk, arst_n, last_take, result_valid)
	`EOS_ASSERT(a_no_overwrite, clk, arst_n, (result_valid && result_stall) |-> !last_take)

endmodule
